// ===== rtl/core/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants for the screen fade sequencer
// Holds the sequencer states, mode and blend codes, field widths and the
// request/response bundle of the shared divide unit.
// ----------------------------------------------------------------------------
package sfs_pkg;

    // Field widths
    localparam int unsigned MODE_W  = 3;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned LEVEL_W = 5;
    localparam int unsigned QUOT_W  = 4;   // progress below full fits in 4 bits
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_TDATA_W  = 24;

    // Full fade level in sixteenths
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 5'd16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSITION_MODE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH    = 4'd1;

    // Transition modes
    localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_OUT_BLACK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IN_BLACK  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_OUT_WHITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_IN_WHITE  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DISSOLVE  = 3'd5;

    // Blend kinds
    localparam logic [KIND_W-1:0] KIND_OFF   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLACK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WHITE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ALPHA = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Divide unit request and response
    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] numer;   // frame count, below denom
        logic [LEN_W-1:0] denom;   // latched length
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== rtl/core/sfs_div_unit.sv =====
// ----------------------------------------------------------------------------
// sfs_div_unit: iterative progress divider
// Computes numer*16/denom for numer below denom with one shared
// compare-and-subtract step per cycle, one quotient bit each step.
// ----------------------------------------------------------------------------
module sfs_div_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  sfs_pkg::div_req_t req,
    output sfs_pkg::div_rsp_t rsp
);

    localparam int unsigned CNT_W = $clog2(sfs_pkg::QUOT_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            step_reg, step_next;
    logic [sfs_pkg::LEN_W-1:0]   rem_reg, rem_next;
    logic [sfs_pkg::LEN_W-1:0]   den_reg, den_next;
    logic [sfs_pkg::QUOT_W-1:0]  quot_reg, quot_next;

    logic [sfs_pkg::LEN_W:0]     shifted;
    logic [sfs_pkg::LEN_W:0]     diff;
    logic                        ge;

    // Shared step: double the remainder, subtract the divisor if it fits
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    // Advance the iteration
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = req.numer;
            den_next  = req.denom;
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[sfs_pkg::LEN_W-1:0] : shifted[sfs_pkg::LEN_W-1:0];
            quot_next = {quot_reg[sfs_pkg::QUOT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == CNT_W'(sfs_pkg::QUOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

`ifndef NO_ASSERTIONS
    // A result appears only at the end of an iteration run
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a preceding run");
    // Remainder stays below the divisor during a run
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> rem_reg < den_reg)
        else $error("divider remainder out of range");
    // Busy and done are never both set
    a_busy_done_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
`endif

endmodule

// ===== rtl/core/screen_fade_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// screen_fade_sequencer_top: frame-driven display transition controller
// Restart transactions arm a fade or dissolve; tick transactions advance the
// frame count and derive progress, brightness and alpha weights.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake        Payload
//  s_       in         s_tvalid/tready  s_tdata[0] restart
//  m_       out        m_tvalid/tready  m_tdata fields listed at the port
//  cfg_     in         cfg_valid/ready  cfg_index, cfg_data
//
//  A restart, an idle tick or a tick at the end of a transition goes straight
//  to emit; any other tick waits in the divide state for the 4-step divider.
//  aresetn is synchronous, active low; it clears the sequencer and state.
//  A result waits in the output register while the next transaction is
//  taken; the sequencer stalls in its emit state while that register is full and m_tready is low.
//  cfg_ready is always high.
//
module screen_fade_sequencer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sfs_pkg::S_TDATA_W-1:0]     s_tdata,  // [0] restart, [7:1] zero
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [1:0] blend_kind, [6:2] brightness_level, [11:7] old_weight,
    // [16:12] new_weight, [21:17] progress_level, [22] running, [23] finished
    output logic [sfs_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfs_pkg::LEN_W-1:0]         cfg_data
);

    sfs_pkg::state_t state_reg, state_next;

    // Configuration registers
    logic [sfs_pkg::MODE_W-1:0]   cfg_mode_reg;
    logic [sfs_pkg::LEN_W-1:0]    cfg_len_reg;

    // Transition state
    logic [sfs_pkg::LEN_W-1:0]    count_reg, count_next;
    logic [sfs_pkg::LEN_W-1:0]    len_reg, len_next;
    logic [sfs_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic                         running_reg, running_next;
    logic                         done_reg, done_next;
    logic [sfs_pkg::LEVEL_W-1:0]  progress_reg, progress_next;
    logic [sfs_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [sfs_pkg::LEVEL_W-1:0]  bright_reg, bright_next;
    logic [sfs_pkg::LEVEL_W-1:0]  old_reg, old_next;
    logic [sfs_pkg::LEVEL_W-1:0]  new_reg, new_next;

    // Output register
    logic                         m_valid_reg, m_valid_next;
    logic [sfs_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;

    logic                         accept;
    logic                         load_out;
    logic                         restart;
    logic [sfs_pkg::LEN_W:0]      count_inc;
    logic                         last_frame;
    logic [sfs_pkg::LEVEL_W-1:0]  quot_level;
    logic [sfs_pkg::LEVEL_W-1:0]  inv_level;

    sfs_pkg::div_req_t div_req;
    sfs_pkg::div_rsp_t div_rsp;

    sfs_div_unit u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign restart    = s_tdata[0];
    assign accept     = s_tvalid && s_tready;
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign last_frame = count_inc >= {1'b0, len_reg};
    assign quot_level = {1'b0, div_rsp.quot};
    assign inv_level  = sfs_pkg::FULL_LEVEL - quot_level;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (!restart && running_reg && !last_frame) begin
                        state_next = sfs_pkg::ST_DIV;
                    end else begin
                        state_next = sfs_pkg::ST_EMIT;
                    end
                end
            end
            sfs_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = sfs_pkg::ST_EMIT;
                end
            end
            sfs_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = sfs_pkg::ST_IDLE;
                end
            end
            default: state_next = sfs_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        load_out      = 1'b0;
        div_req.start = 1'b0;
        div_req.numer = count_inc[sfs_pkg::LEN_W-1:0];
        div_req.denom = len_reg;
        case (state_reg)
            sfs_pkg::ST_IDLE: begin
                s_tready      = 1'b1;
                div_req.start = s_tvalid && !restart && running_reg && !last_frame;
            end
            sfs_pkg::ST_DIV: begin
            end
            sfs_pkg::ST_EMIT: begin
                load_out = !m_valid_reg || m_tready;
            end
            default: begin
            end
        endcase
    end

    // Update transition state on accepted transactions and divider results
    always_comb begin
        count_next    = count_reg;
        len_next      = len_reg;
        mode_next     = mode_reg;
        running_next  = running_reg;
        done_next     = done_reg;
        progress_next = progress_reg;
        kind_next     = kind_reg;
        bright_next   = bright_reg;
        old_next      = old_reg;
        new_next      = new_reg;
        if (accept) begin
            if (restart) begin
                mode_next     = cfg_mode_reg;
                count_next    = '0;
                len_next      = (cfg_len_reg == '0) ? sfs_pkg::LEN_W'(1) : cfg_len_reg;
                running_next  = 1'b1;
                done_next     = 1'b0;
                progress_next = '0;
            end else if (running_reg) begin
                count_next = count_inc[sfs_pkg::LEN_W-1:0];
                if (last_frame) begin
                    running_next  = 1'b0;
                    done_next     = 1'b1;
                    mode_next     = sfs_pkg::MODE_NONE;
                    progress_next = '0;
                    kind_next     = sfs_pkg::KIND_OFF;
                    bright_next   = '0;
                    old_next      = '0;
                    new_next      = '0;
                end
            end
        end else if (state_reg == sfs_pkg::ST_DIV && div_rsp.done) begin
            progress_next = quot_level;
            case (mode_reg)
                sfs_pkg::MODE_OUT_BLACK: begin
                    kind_next   = sfs_pkg::KIND_BLACK;
                    bright_next = quot_level;
                end
                sfs_pkg::MODE_IN_BLACK: begin
                    kind_next   = sfs_pkg::KIND_BLACK;
                    bright_next = inv_level;
                end
                sfs_pkg::MODE_OUT_WHITE: begin
                    kind_next   = sfs_pkg::KIND_WHITE;
                    bright_next = quot_level;
                end
                sfs_pkg::MODE_IN_WHITE: begin
                    kind_next   = sfs_pkg::KIND_WHITE;
                    bright_next = inv_level;
                end
                sfs_pkg::MODE_DISSOLVE: begin
                    kind_next = sfs_pkg::KIND_ALPHA;
                    old_next  = inv_level;
                    new_next  = quot_level;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold or load the output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = {!running_reg || done_reg, running_reg, progress_reg,
                            new_reg, old_reg, bright_reg, kind_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sfs_pkg::ST_IDLE;
            cfg_mode_reg <= sfs_pkg::MODE_NONE;
            cfg_len_reg  <= sfs_pkg::LEN_W'(1);
            count_reg    <= '0;
            len_reg      <= sfs_pkg::LEN_W'(1);
            mode_reg     <= sfs_pkg::MODE_NONE;
            running_reg  <= 1'b0;
            done_reg     <= 1'b0;
            progress_reg <= '0;
            kind_reg     <= sfs_pkg::KIND_OFF;
            bright_reg   <= '0;
            old_reg      <= '0;
            new_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            mode_reg     <= mode_next;
            running_reg  <= running_next;
            done_reg     <= done_next;
            progress_reg <= progress_next;
            kind_reg     <= kind_next;
            bright_reg   <= bright_next;
            old_reg      <= old_next;
            new_reg      <= new_next;
            m_valid_reg  <= m_valid_next;
            // Register writes; other indexes drop
            if (cfg_valid) begin
                if (cfg_index == sfs_pkg::CFG_TRANSITION_MODE) begin
                    cfg_mode_reg <= cfg_data[sfs_pkg::MODE_W-1:0];
                end else if (cfg_index == sfs_pkg::CFG_FRAME_LENGTH) begin
                    cfg_len_reg <= cfg_data;
                end
            end
        end
        m_data_reg <= m_data_next;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

`ifndef NO_ASSERTIONS
    // The frame count stays below the latched length while running
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> count_reg < len_reg)
        else $error("frame count reached length while running");
    // Progress reads zero whenever no transition runs
    a_idle_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> progress_reg == '0)
        else $error("progress nonzero while idle");
    // A divide run belongs to a running transition
    a_div_running: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sfs_pkg::ST_DIV |-> running_reg)
        else $error("divide state without a running transition");
    // Divider results arrive only while the sequencer waits for them
    a_div_rsp_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == sfs_pkg::ST_DIV)
        else $error("divider result outside the divide state");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the screen fade sequencer
// Drives restart and tick transactions through the input stream, programs the
// mode and length registers between phases, and checks every result against
// a cycle-free model of the transition logic kept in a small scoreboard.
// ----------------------------------------------------------------------------

// Result fields from the highest bit down, matching m_tdata
typedef struct packed {
    logic       finished;
    logic       running;
    logic [4:0] progress;
    logic [4:0] new_w;
    logic [4:0] old_w;
    logic [4:0] bright;
    logic [1:0] kind;
} blend_frame_t;

// Tracks the fade sequencer's registers and transition state and holds the
// frames it is expected to emit, oldest first.
class fade_scoreboard;
    logic [2:0]   mode_reg;
    logic [15:0]  length_reg;
    logic [15:0]  frame_cnt;
    logic [15:0]  run_length;
    logic [2:0]   run_mode;
    bit           run_on;
    bit           done_on;
    logic [1:0]   kind_q;
    logic [4:0]   bright_q;
    logic [4:0]   old_q;
    logic [4:0]   new_q;
    blend_frame_t expected_frames[$];
    int           errors;

    function new();
        mode_reg   = sfs_pkg::MODE_NONE;
        length_reg = 16'd1;
        frame_cnt  = '0;
        run_length = 16'd1;
        run_mode   = sfs_pkg::MODE_NONE;
        run_on     = 1'b0;
        done_on    = 1'b0;
        kind_q     = sfs_pkg::KIND_OFF;
        bright_q   = '0;
        old_q      = '0;
        new_q      = '0;
        errors     = 0;
    endfunction

    // Fade level in sixteenths for the current frame
    function logic [4:0] fade_level();
        int unsigned q;
        if (!run_on) return '0;
        if (frame_cnt >= run_length) return sfs_pkg::FULL_LEVEL;
        q = (32'(frame_cnt) * 32'(sfs_pkg::FULL_LEVEL)) / 32'(run_length);
        return 5'(q);
    endfunction

    function void write_reg(logic [3:0] idx, logic [15:0] data);
        if (idx == sfs_pkg::CFG_TRANSITION_MODE) mode_reg = data[2:0];
        else if (idx == sfs_pkg::CFG_FRAME_LENGTH) length_reg = data;
    endfunction

    // Advance the transition for one accepted input and queue its frame
    function void note_item(bit restart);
        logic [4:0]   p;
        blend_frame_t f;
        if (restart) begin
            run_mode   = mode_reg;
            frame_cnt  = '0;
            run_length = (length_reg == 16'd0) ? 16'd1 : length_reg;
            run_on     = 1'b1;
            done_on    = 1'b0;
        end else if (run_on) begin
            frame_cnt = frame_cnt + 16'd1;
            p = fade_level();
            case (run_mode)
                sfs_pkg::MODE_OUT_BLACK: begin
                    kind_q = sfs_pkg::KIND_BLACK; bright_q = p;
                end
                sfs_pkg::MODE_IN_BLACK: begin
                    kind_q = sfs_pkg::KIND_BLACK; bright_q = sfs_pkg::FULL_LEVEL - p;
                end
                sfs_pkg::MODE_OUT_WHITE: begin
                    kind_q = sfs_pkg::KIND_WHITE; bright_q = p;
                end
                sfs_pkg::MODE_IN_WHITE: begin
                    kind_q = sfs_pkg::KIND_WHITE; bright_q = sfs_pkg::FULL_LEVEL - p;
                end
                sfs_pkg::MODE_DISSOLVE: begin
                    kind_q = sfs_pkg::KIND_ALPHA;
                    old_q  = sfs_pkg::FULL_LEVEL - p;
                    new_q  = p;
                end
                default: ;
            endcase
            // Final frame: end the transition and clear the blend outputs
            if (frame_cnt >= run_length) begin
                run_on   = 1'b0;
                done_on  = 1'b1;
                run_mode = sfs_pkg::MODE_NONE;
                kind_q   = sfs_pkg::KIND_OFF;
                bright_q = '0;
                old_q    = '0;
                new_q    = '0;
            end
        end
        f.kind     = kind_q;
        f.bright   = bright_q;
        f.old_w    = old_q;
        f.new_w    = new_q;
        f.progress = fade_level();
        f.running  = run_on;
        f.finished = !run_on || done_on;
        expected_frames.push_back(f);
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("%s", msg);
    endtask

    // Compare one accepted result with the oldest expected frame
    task check_frame(logic [23:0] data);
        blend_frame_t got;
        blend_frame_t want;
        got = blend_frame_t'(data);
        if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", data));
            return;
        end
        want = expected_frames.pop_front();
        if (got.kind !== want.kind || got.bright !== want.bright ||
            got.old_w !== want.old_w || got.new_w !== want.new_w ||
            got.progress !== want.progress || got.running !== want.running ||
            got.finished !== want.finished)
            report_mismatch($sformatf(
                {"frame: kind %0d/%0d bright %0d/%0d old %0d/%0d new %0d/%0d",
                 " prog %0d/%0d run %0d/%0d fin %0d/%0d"},
                want.kind, got.kind, want.bright, got.bright, want.old_w, got.old_w,
                want.new_w, got.new_w, want.progress, got.progress,
                want.running, got.running, want.finished, got.finished));
    endtask

    function int pending();
        return expected_frames.size();
    endfunction

    task check_drained();
        if (expected_frames.size() != 0)
            report_mismatch($sformatf("%0d expected frames never arrived",
                                      expected_frames.size()));
    endtask
endclass

module tb_top;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 20;
    localparam logic [2:0]  MODE_UNDEF_HI  = 3'd7;
    localparam logic [3:0]  CFG_NO_REG     = 4'd15;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sfs_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sfs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [sfs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sfs_pkg::LEN_W-1:0]     cfg_data;

    int src_idle_pct  = 17;
    int sink_idle_pct = 68;
    int quiet_cycles  = 0;

    fade_scoreboard sb = new();

    screen_fade_sequencer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Stall the result stream at random
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Observe every transaction and watch for a hung block
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready) sb.note_item(s_tdata[0]);
            if (m_tvalid && m_tready) sb.check_frame(m_tdata);
            if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) ||
                (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("screen_fade_sequencer_top: mismatch");
                $finish;
            end
        end
    end

    // Offer one input transaction, with random gaps ahead of it
    task automatic send_item(bit restart);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(sfs_pkg::S_TDATA_W-1){1'b0}}, restart};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic cfg_write(logic [3:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the input and wait for every outstanding result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic run_transition(int ticks);
        send_item(1'b1);
        repeat (ticks) send_item(1'b0);
    endtask

    // Mostly complete transitions with random settings, some cut short by a
    // restart, some random noise
    task automatic random_phase(int budget);
        int sent;
        int r;
        int len_eff;
        int ticks;
        int k;
        logic [15:0] len;
        sent = 0;
        while (sent < budget) begin
            wait_drained();
            r = $urandom_range(99);
            if (r < 70)
                cfg_write(sfs_pkg::CFG_TRANSITION_MODE, 16'($urandom_range(65535)));
            if (r < 50 || r >= 90) begin
                k = $urandom_range(99);
                if (k < 5)       len = 16'd0;
                else if (k < 9)  len = 16'hFFFF;
                else if (k < 13) len = 16'($urandom_range(24, 120));
                else             len = 16'($urandom_range(1, 20));
                cfg_write(sfs_pkg::CFG_FRAME_LENGTH, len);
            end
            if ($urandom_range(99) < 4)
                cfg_write(4'($urandom_range(2, 15)), 16'($urandom_range(65535)));
            len_eff = (sb.length_reg == 16'd0) ? 1 : int'(sb.length_reg);
            r = $urandom_range(99);
            if (r < 75) begin
                ticks = (len_eff > 1000) ? $urandom_range(0, 4)
                                         : len_eff + $urandom_range(0, 2);
                run_transition(ticks);
                sent += ticks + 1;
            end else if (r < 90) begin
                ticks = $urandom_range(0, (len_eff > 1000) ? 4 : len_eff);
                run_transition(ticks);
                sent += ticks + 1;
            end else begin
                k = $urandom_range(1, 6);
                repeat (k) send_item(1'($urandom_range(1)));
                sent += k;
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle tick, default settings, every mode, length extremes
        send_item(1'b0);
        run_transition(1);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'd0, sfs_pkg::MODE_OUT_BLACK});
        cfg_write(sfs_pkg::CFG_FRAME_LENGTH, 16'd2);
        run_transition(2);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'd0, sfs_pkg::MODE_IN_BLACK});
        run_transition(2);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'd0, sfs_pkg::MODE_OUT_WHITE});
        cfg_write(sfs_pkg::CFG_FRAME_LENGTH, 16'hFFFF);
        run_transition(2);
        // restart in the middle of a long transition
        run_transition(1);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'd0, sfs_pkg::MODE_IN_WHITE});
        cfg_write(sfs_pkg::CFG_FRAME_LENGTH, 16'd1);
        run_transition(1);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'd0, sfs_pkg::MODE_DISSOLVE});
        cfg_write(sfs_pkg::CFG_FRAME_LENGTH, 16'd0);
        run_transition(1);
        wait_drained();
        cfg_write(sfs_pkg::CFG_TRANSITION_MODE, {13'h1FFF, MODE_UNDEF_HI});
        cfg_write(sfs_pkg::CFG_FRAME_LENGTH, 16'd3);
        cfg_write(CFG_NO_REG, 16'h5555);
        run_transition(3);
        send_item(1'b0);

        // Random: receiver-heavy idling, then sender-heavy, then none
        random_phase(250);
        src_idle_pct  = 68;
        sink_idle_pct = 17;
        random_phase(250);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_drained();
        if (sb.errors == 0)
            $display("screen_fade_sequencer_top: match");
        else
            $display("screen_fade_sequencer_top: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/sfs_pkg.sv
rtl/core/sfs_div_unit.sv
rtl/core/screen_fade_sequencer_top.sv
sim/tb_top.sv
